// ===== sv/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// shared constants and types for the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int DEF_MAX_PATTERN  = 16;
  localparam int DEF_ADDRESS_BITS = 48;

  localparam int DATA_W      = 8;
  localparam int ADDR_OUT_W  = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int REG_SIG_BYTES = 16;
  localparam int LEN_REG_W   = 5;
  localparam int CARE_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_BASE_ADDRESS   = 3'd4
  } cfg_reg_t;

endpackage

// ===== sv/wbps_in_if.sv =====
// ----------------------------------------------------------------------------
// wbps_in_if
// input byte channel: one data byte and a region end flag per word
// ----------------------------------------------------------------------------
interface wbps_in_if;
  import wbps_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

// ===== sv/wbps_out_if.sv =====
// ----------------------------------------------------------------------------
// wbps_out_if
// result channel: found flag and match start address per word
// ----------------------------------------------------------------------------
interface wbps_out_if;
  import wbps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [ADDR_OUT_W-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

// ===== sv/wbps_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wbps_cfg_if
// register write channel: register index and write data per word
// ----------------------------------------------------------------------------
interface wbps_cfg_if;
  import wbps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/wildcard_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// finds the first masked signature match per byte-stream region, reports its address
// ----------------------------------------------------------------------------
// path: a causing byte is registered in the cell chain and compare stage, its result word in the output register
// throughput: one byte per cycle unless stalled, set by the cell chain shifting once per word
// a waiting result word stalls bytes once the compare stage also holds a byte
// reset: synchronous active-low rst_n loads register defaults, clears fill and state
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN  = wbps_pkg::DEF_MAX_PATTERN,
  parameter int ADDRESS_BITS = wbps_pkg::DEF_ADDRESS_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  wbps_in_if.sink    in_ch,
  wbps_out_if.source out_ch,
  wbps_cfg_if.sink   cfg_ch
);
  import wbps_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int SUM_W = (ADDRESS_BITS > ADDR_OUT_W) ? ADDRESS_BITS : ADDR_OUT_W;
  localparam logic [SUM_W-1:0] SUM_MASK = {SUM_W{1'b1}} >> (SUM_W - ADDRESS_BITS);

  // configuration registers
  logic [CFG_DATA_W-1:0] pattern_low_r;
  logic [CFG_DATA_W-1:0] pattern_high_r;
  logic [CARE_W-1:0]     care_mask_r;
  logic [LEN_REG_W-1:0]  pattern_length_r;
  logic [ADDR_OUT_W-1:0] base_address_r;

  logic [LEN_W-1:0] eff_len;
  logic [MAX_PATTERN-1:0][DATA_W-1:0] sig_bytes;
  logic [MAX_PATTERN-1:0]             sig_care;

  // input stage
  logic                    in_acc;
  logic [ADDRESS_BITS-1:0] offset_r;
  logic [ADDRESS_BITS-1:0] offset_nxt;
  logic                    restart_r;

  // compare stage
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  logic                    s1_last_r;
  logic [ADDRESS_BITS-1:0] s1_start_r;
  logic                    match_done_r;
  logic                    match_done_nxt;
  logic                    hit;
  logic                    s1_hit;
  logic                    s1_result;
  logic [SUM_W-1:0]        sum_full;
  logic [SUM_W-1:0]        sum_masked;

  // output register
  logic                  out_free;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  found_r;
  logic [ADDR_OUT_W-1:0] addr_r;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      care_mask_r      <= '0;
      pattern_length_r <= LEN_REG_W'(1);
      base_address_r   <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_PATTERN_LOW:    pattern_low_r    <= cfg_ch.data;
        REG_PATTERN_HIGH:   pattern_high_r   <= cfg_ch.data;
        REG_CARE_MASK:      care_mask_r      <= cfg_ch.data[CARE_W-1:0];
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_ch.data[LEN_REG_W-1:0];
        REG_BASE_ADDRESS:   base_address_r   <= cfg_ch.data[ADDR_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(pattern_length_r) > MAX_PATTERN) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(pattern_length_r);
    end
  end

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_sig
      if (k < REG_SIG_BYTES / 2) begin : g_low
        assign sig_bytes[k] = pattern_low_r[DATA_W*k +: DATA_W];
        assign sig_care[k]  = care_mask_r[k];
      end else if (k < REG_SIG_BYTES) begin : g_high
        assign sig_bytes[k] = pattern_high_r[DATA_W*(k - REG_SIG_BYTES/2) +: DATA_W];
        assign sig_care[k]  = care_mask_r[k];
      end else begin : g_wild
        assign sig_bytes[k] = '0;
        assign sig_care[k]  = 1'b0;
      end
    end
  endgenerate

  // ---------------- handshake ----------------
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // ---------------- input stage ----------------
  always_comb begin
    offset_nxt = offset_r;
    if (in_acc) begin
      offset_nxt = in_ch.region_end ? '0 : offset_r + ADDRESS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      restart_r <= 1'b0;
    end else begin
      offset_r <= offset_nxt;
      if (in_acc) begin
        restart_r <= in_ch.region_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r  <= in_ch.region_end;
      s1_start_r <= offset_r - ADDRESS_BITS'(eff_len - LEN_W'(1));
    end
  end

  wbps_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (in_acc),
    .restart   (restart_r),
    .byte_in   (in_ch.data_byte),
    .eff_len   (eff_len),
    .sig_bytes (sig_bytes),
    .sig_care  (sig_care),
    .hit       (hit)
  );

  // ---------------- compare stage ----------------
  assign s1_hit     = s1_valid_r && !match_done_r && hit;
  assign s1_result  = s1_valid_r && !match_done_r && (hit || s1_last_r);
  assign sum_full   = SUM_W'(base_address_r) + SUM_W'(s1_start_r);
  assign sum_masked = sum_full & SUM_MASK;

  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    match_done_nxt = match_done_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_valid_r && out_free) begin
      if (s1_last_r) begin
        match_done_nxt = 1'b0;
      end else if (s1_hit) begin
        match_done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      match_done_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      match_done_r <= match_done_nxt;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_result) begin
      found_r <= s1_hit;
      addr_r  <= s1_hit ? sum_masked[ADDR_OUT_W-1:0] : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = found_r;
  assign out_ch.match_address = addr_r;

  // ---------------- assertions ----------------
  a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.match_address == '0)
    else $error("no-match word carries a nonzero address");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with empty compare stage");

  a_region_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.region_end |=> offset_r == '0 && restart_r)
    else $error("region state not restarted after last byte");

  a_done_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free && s1_last_r |=> !match_done_r)
    else $error("match flag survives region end");

endmodule

// ===== sv/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// wbps_cell
// one window position: holds a byte and its fill flag, compares to signature
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic [wbps_pkg::DATA_W-1:0] byte_in,
  input  logic                      fill_in,
  input  logic [wbps_pkg::DATA_W-1:0] exp_byte,
  input  logic                      care,
  output logic [wbps_pkg::DATA_W-1:0] byte_out,
  output logic                      fill_out,
  output logic                      ok
);
  import wbps_pkg::*;

  logic [DATA_W-1:0] byte_r;
  logic [DATA_W-1:0] byte_nxt;
  logic              fill_r;
  logic              fill_nxt;

  always_comb begin
    byte_nxt = byte_r;
    fill_nxt = fill_r;
    if (shift) begin
      byte_nxt = byte_in;
      fill_nxt = fill_in;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign byte_out = byte_r;
  assign fill_out = fill_r;
  assign ok       = !care || (byte_r == exp_byte);

endmodule

// ===== sv/wbps_window.sv =====
// ----------------------------------------------------------------------------
// wbps_window
// chain of window cells with per-position signature alignment and match
// ----------------------------------------------------------------------------
module wbps_window #(
  parameter  int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN,
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      shift,
  input  logic                                      restart,
  input  logic [wbps_pkg::DATA_W-1:0]               byte_in,
  input  logic [LEN_W-1:0]                          eff_len,
  input  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] sig_bytes,
  input  logic [MAX_PATTERN-1:0]                    sig_care,
  output logic                                      hit
);
  import wbps_pkg::*;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0][DATA_W-1:0] byte_q;
  logic [MAX_PATTERN-1:0]             fill_q;
  logic [MAX_PATTERN-1:0]             ok_vec;
  logic [LEN_W-1:0]                   last_pos;

  genvar j;
  generate
    for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [DATA_W-1:0] cell_byte_in;
      logic              cell_fill_in;
      logic [LEN_W-1:0]  sig_pos;
      logic              in_use;

      if (j == 0) begin : g_head
        assign cell_byte_in = byte_in;
        assign cell_fill_in = 1'b1;
      end else begin : g_body
        assign cell_byte_in = byte_q[j-1];
        assign cell_fill_in = fill_q[j-1] & ~restart;
      end

      // window position j lines up with signature byte len-1-j
      assign sig_pos = eff_len - LEN_W'(j + 1);
      assign in_use  = LEN_W'(j) < eff_len;

      wbps_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .byte_in  (cell_byte_in),
        .fill_in  (cell_fill_in),
        .exp_byte (sig_bytes[sig_pos[IDX_W-1:0]]),
        .care     (in_use && sig_care[sig_pos[IDX_W-1:0]]),
        .byte_out (byte_q[j]),
        .fill_out (fill_q[j]),
        .ok       (ok_vec[j])
      );
    end
  endgenerate

  assign last_pos = eff_len - LEN_W'(1);
  assign hit      = (&ok_vec) && fill_q[last_pos[IDX_W-1:0]];

endmodule
